/* rtl/xyr_pkg.sv */
package xyr_pkg;

  // Sizing
  localparam int QueueDepth = 16;
  localparam int PortCount  = 5;
  localparam int FlitBits   = 32;
  localparam int PortW      = 3;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int CoordW     = 8;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 8;

  // Destination fields inside a flit
  localparam int DstXLsb = 24;
  localparam int DstYLsb = 16;

  // Port codes
  localparam logic [PortW-1:0] PortEast  = 3'd0;
  localparam logic [PortW-1:0] PortWest  = 3'd1;
  localparam logic [PortW-1:0] PortNorth = 3'd2;
  localparam logic [PortW-1:0] PortSouth = 3'd3;
  localparam logic [PortW-1:0] PortLocal = 3'd4;

  // Operation codes
  localparam logic OpArrive = 1'b0;
  localparam logic OpTick   = 1'b1;

  // Result status codes
  localparam logic StatusFwd  = 1'b0;
  localparam logic StatusDrop = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRouterX   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRouterY   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgConnPorts = 2'd2;

  localparam logic [PortCount-1:0] ConnPortsReset = '1;

  typedef struct packed {
    logic                op;
    logic [PortW-1:0]    in_port;
    logic [FlitBits-1:0] flit;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [PortW-1:0]    out_port;
    logic [FlitBits-1:0] out_flit;
  } out_item_t;

  // Queue control from the router core
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  // Queue status back to the router core
  typedef struct packed {
    logic [CntW-1:0]     count;
    logic [FlitBits-1:0] head_flit;
  } fifo_stat_t;

  // Dimension-ordered routing: X first, then Y
  function automatic logic [PortW-1:0] xy_route(input logic [FlitBits-1:0] f,
                                                 input logic [CoordW-1:0]  rx,
                                                 input logic [CoordW-1:0]  ry);
    logic [CoordW-1:0] tx;
    logic [CoordW-1:0] ty;
    logic [PortW-1:0]  port;
    tx = f[DstXLsb +: CoordW];
    ty = f[DstYLsb +: CoordW];
    if (rx == tx) begin
      if (ry == ty) begin
        port = PortLocal;
      end else if (ry > ty) begin
        port = PortSouth;
      end else begin
        port = PortNorth;
      end
    end else if (rx > tx) begin
      port = PortWest;
    end else begin
      port = PortEast;
    end
    return port;
  endfunction

endpackage

/* rtl/xy_wormhole_router_5port_top.sv */
// Path: a result passes through the input register and then the result register.
// Throughput: one item (flit arrival or router tick) per cycle while the result side keeps up;
// the single queue-update stage between the two registers sets that rate.
// Reset: all queues empty, local port polled first, arbitration mode, coordinates 0,
// all five links connected. Queue storage is not cleared.
module xy_wormhole_router_5port_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  xyr_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output xyr_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [xyr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [xyr_pkg::CfgDataW-1:0]   cfg_data_i
);

  // Pipeline registers
  logic                  in_valid_q;
  xyr_pkg::in_item_t     in_q;
  logic                  out_valid_q;
  xyr_pkg::out_item_t    out_q;

  // Configuration
  logic [xyr_pkg::CoordW-1:0]    rx_q, ry_q;
  logic [xyr_pkg::PortCount-1:0] conn_q;

  // Arbiter state
  logic [xyr_pkg::PortW-1:0] poll_q, poll_d;
  logic                      worm_q, worm_d;
  logic [xyr_pkg::PortW-1:0] src_q, src_d;
  logic [xyr_pkg::PortW-1:0] tgt_q, tgt_d;
  logic [xyr_pkg::CntW-1:0]  left_q, left_d;

  xyr_pkg::fifo_ctrl_t ctrl [xyr_pkg::PortCount];
  xyr_pkg::fifo_stat_t stat [xyr_pkg::PortCount];

  logic                out_free, advance;
  logic                res_valid;
  xyr_pkg::out_item_t  res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign cfg_ready_o = 1'b1;

  // Per-port input queues
  for (genvar p = 0; p < xyr_pkg::PortCount; p++) begin : g_fifo
    xyr_fifo u_fifo (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[p]),
      .wdata_i(in_q.flit),
      .stat_o (stat[p])
    );
  end

  // Item processing: arrival, wormhole forward, or arbitration poll
  always_comb begin
    logic drop;
    xyr_pkg::fifo_stat_t sel;
    for (int p = 0; p < xyr_pkg::PortCount; p++) begin
      ctrl[p] = '0;
    end
    res_valid = 1'b0;
    res       = '0;
    poll_d    = poll_q;
    worm_d    = worm_q;
    src_d     = src_q;
    tgt_d     = tgt_q;
    left_d    = left_q;
    drop      = 1'b1;
    sel       = stat[worm_q ? src_q : poll_q];
    if (advance) begin
      unique case (in_q.op)
        xyr_pkg::OpArrive: begin
          if (in_q.in_port < xyr_pkg::PortW'(xyr_pkg::PortCount)) begin
            if (conn_q[in_q.in_port] &&
                stat[in_q.in_port].count < xyr_pkg::CntW'(xyr_pkg::QueueDepth)) begin
              drop = 1'b0;
              ctrl[in_q.in_port].push = 1'b1;
            end
          end
          if (drop) begin
            res_valid    = 1'b1;
            res.status   = xyr_pkg::StatusDrop;
            res.out_port = in_q.in_port;
            res.out_flit = in_q.flit;
          end
        end
        xyr_pkg::OpTick: begin
          if (worm_q) begin
            ctrl[src_q].pop = 1'b1;
            res_valid    = 1'b1;
            res.status   = xyr_pkg::StatusFwd;
            res.out_port = tgt_q;
            res.out_flit = (sel.count != '0) ? sel.head_flit : '0;
            if (left_q != '0) begin
              left_d = left_q - 1'b1;
            end
            if (left_d == '0) begin
              worm_d = 1'b0;
            end
          end else begin
            if (conn_q[poll_q] && sel.count != '0) begin
              worm_d = 1'b1;
              src_d  = poll_q;
              tgt_d  = xyr_pkg::xy_route(sel.head_flit, rx_q, ry_q);
              left_d = sel.count;
            end
            poll_d = (poll_q == xyr_pkg::PortLocal) ? xyr_pkg::PortEast : poll_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      poll_q      <= xyr_pkg::PortLocal;
      worm_q      <= 1'b0;
      src_q       <= '0;
      tgt_q       <= '0;
      left_q      <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      conn_q      <= xyr_pkg::ConnPortsReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= advance && res_valid;
      end
      poll_q <= poll_d;
      worm_q <= worm_d;
      src_q  <= src_d;
      tgt_q  <= tgt_d;
      left_q <= left_d;
      // Configuration transfer
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          xyr_pkg::CfgRouterX:   rx_q   <= cfg_data_i;
          xyr_pkg::CfgRouterY:   ry_q   <= cfg_data_i;
          xyr_pkg::CfgConnPorts: conn_q <= cfg_data_i[xyr_pkg::PortCount-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/xyr_fifo.sv */
module xyr_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  xyr_pkg::fifo_ctrl_t           ctrl_i,
  input  logic [xyr_pkg::FlitBits-1:0]  wdata_i,
  output xyr_pkg::fifo_stat_t           stat_o
);

  logic [xyr_pkg::FlitBits-1:0] store_q [xyr_pkg::QueueDepth];
  logic [xyr_pkg::PtrW-1:0]     head_q, head_d;
  logic [xyr_pkg::CntW-1:0]     count_q, count_d;
  logic [xyr_pkg::PtrW-1:0]     tail;
  logic [xyr_pkg::CntW:0]       tail_sum;
  logic                         do_push, do_pop;

  // Pop only when there is something to pop; push is gated by the core
  assign do_push = ctrl_i.push;
  assign do_pop  = ctrl_i.pop && (count_q != '0);

  // Tail slot with wrap
  always_comb begin
    tail_sum = {1'b0, (xyr_pkg::CntW)'(head_q)} + {1'b0, count_q};
    if (tail_sum >= (xyr_pkg::CntW + 1)'(xyr_pkg::QueueDepth)) begin
      tail_sum = tail_sum - (xyr_pkg::CntW + 1)'(xyr_pkg::QueueDepth);
    end
    tail = tail_sum[xyr_pkg::PtrW-1:0];
  end

  // Pointer and count update
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (do_pop) begin
      head_d  = (head_q == xyr_pkg::PtrW'(xyr_pkg::QueueDepth - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end else if (do_push) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Flit storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[tail] <= wdata_i;
    end
  end

  assign stat_o.count     = count_q;
  assign stat_o.head_flit = store_q[head_q];

endmodule

/* rtl/xyr_checker.sv */
module xyr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input xyr_pkg::out_item_t           out_item_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Input side only backs up when the result side is stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // Forwarded flits always leave on a real port
  a_fwd_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == xyr_pkg::StatusFwd |->
      out_item_o.out_port <= xyr_pkg::PortLocal)
    else $error("forward to a nonexistent port");

  // No result rises without a matching earlier input transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input transfer");

endmodule

bind xy_wormhole_router_5port_top xyr_checker u_xyr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

/* tb/tb_xy_wormhole_router_5port_top.sv */
`timescale 1ns / 1ps

module tb_xy_wormhole_router_5port_top;
  import xyr_pkg::*;

  localparam int SettleCycles = 4;     // result path is two registers deep
  localparam int StallLimit   = 2000;  // cycles without any transfer
  localparam int PrintCap     = 100;
  localparam int ItemBits     = $bits(in_item_t);
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;  // unmapped register index

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_item_t            in_item_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                cfg_ready_o;
  out_item_t           out_item_o;

  xy_wormhole_router_5port_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Router shadow state
  logic [CoordW-1:0]    rtr_x;
  logic [CoordW-1:0]    rtr_y;
  logic [PortCount-1:0] link_mask;
  logic [FlitBits-1:0]  port_fifo [PortCount][QueueDepth];
  int unsigned          fifo_rd   [PortCount];
  int unsigned          fifo_fill [PortCount];
  int unsigned          poll_ptr;
  bit                   worm_active;
  int unsigned          worm_src;
  logic [PortW-1:0]     worm_dst;
  int unsigned          worm_left;

  out_item_t egress_q[$];  // router outputs still to come, oldest first
  int        mismatch_cnt = 0;
  int        burst_left   = 0;
  bit        gaps_on      = 1'b0;

  function automatic logic [PortW-1:0] dim_order_port(logic [FlitBits-1:0] f);
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    dx = f[DstXLsb +: CoordW];
    dy = f[DstYLsb +: CoordW];
    // resolve X first, Y only once X matches
    if (dx != rtr_x) return (dx < rtr_x) ? PortWest : PortEast;
    if (dy == rtr_y) return PortLocal;
    return (dy < rtr_y) ? PortSouth : PortNorth;
  endfunction

  function automatic bit link_up(logic [PortW-1:0] p);
    if (p >= PortCount) return 1'b0;
    return link_mask[p];
  endfunction

  function automatic void shadow_reset();
    rtr_x       = '0;
    rtr_y       = '0;
    link_mask   = ConnPortsReset;
    poll_ptr    = 32'(PortLocal);
    worm_active = 1'b0;
    worm_src    = 0;
    worm_dst    = PortEast;
    worm_left   = 0;
    for (int p = 0; p < PortCount; p++) begin
      fifo_rd[p]   = 0;
      fifo_fill[p] = 0;
    end
  endfunction

  // Advance the shadow router by one accepted item; queue any output it causes
  function automatic void router_step(in_item_t it);
    out_item_t   r;
    int unsigned p;
    if (it.op == OpArrive) begin
      p = 32'(it.in_port);
      if (!link_up(it.in_port) || fifo_fill[p] >= QueueDepth) begin
        r.status   = StatusDrop;
        r.out_port = it.in_port;
        r.out_flit = it.flit;
        egress_q.push_back(r);
      end else begin
        port_fifo[p][(fifo_rd[p] + fifo_fill[p]) % QueueDepth] = it.flit;
        fifo_fill[p]++;
      end
      return;
    end
    // wormhole: pop one flit from the captured source, links not consulted
    if (worm_active) begin
      p = worm_src;
      r.status   = StatusFwd;
      r.out_port = worm_dst;
      r.out_flit = '0;
      if (fifo_fill[p] > 0) begin
        r.out_flit = port_fifo[p][fifo_rd[p]];
        fifo_rd[p] = (fifo_rd[p] + 1) % QueueDepth;
        fifo_fill[p]--;
      end
      if (worm_left > 0) worm_left--;
      if (worm_left == 0) worm_active = 1'b0;
      egress_q.push_back(r);
      return;
    end
    // arbitration: poll one port, capture its length on a hit
    p = poll_ptr;
    if (link_up(p[PortW-1:0]) && fifo_fill[p] > 0) begin
      worm_active = 1'b1;
      worm_src    = p;
      worm_dst    = dim_order_port(port_fifo[p][fifo_rd[p]]);
      worm_left   = fifo_fill[p];
    end
    poll_ptr = (p + 1) % PortCount;
  endfunction

  task automatic report_mismatch(string what, logic [FlitBits-1:0] got,
                                 logic [FlitBits-1:0] want);
    if (mismatch_cnt < PrintCap)
      $display("%0t: mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (egress_q.size() == 0) begin
        report_mismatch("result with none expected", out_item_o.out_flit, '0);
      end else begin
        want = egress_q.pop_front();
        if (out_item_o.status !== want.status)
          report_mismatch("status", FlitBits'(out_item_o.status),
                          FlitBits'(want.status));
        if (out_item_o.out_port !== want.out_port)
          report_mismatch("out_port", FlitBits'(out_item_o.out_port),
                          FlitBits'(want.out_port));
        if (out_item_o.out_flit !== want.out_flit)
          report_mismatch("out_flit", out_item_o.out_flit, want.out_flit);
      end
    end
  end

  // Output backpressure, in a random pattern that is picked anew periodically
  int unsigned stall_cyc  = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 96 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 9) < 7);
      2:       out_ready_i <= (stall_cyc % 6) > 1;
      default: out_ready_i <= (stall_cyc % 3) == 0;
    endcase
  end

  // Watchdog on cycles with no transfer anywhere
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("xy_wormhole_router_5port_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transfer; valid stays up between back-to-back items
  task automatic send_item(in_item_t it);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    router_step(it);
  endtask

  task automatic arrive(logic [PortW-1:0] p, logic [FlitBits-1:0] f);
    send_item('{op: OpArrive, in_port: p, flit: f});
  endtask

  // Tick items carry random don't-care fields
  task automatic tick(int n);
    repeat (n) send_item('{op: OpTick, in_port: PortW'($urandom),
                           flit: FlitBits'($urandom)});
  endtask

  // Hold input until every expected result has left, then let the pipe settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (egress_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgRouterX:   rtr_x     = data;
      CfgRouterY:   rtr_y     = data;
      CfgConnPorts: link_mask = data[PortCount-1:0];
      default: ;
    endcase
  endtask

  task automatic set_router(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                            logic [CfgDataW-1:0] links, bit spare);
    drain_results();
    cfg_write(CfgRouterX, x);
    cfg_write(CfgRouterY, y);
    cfg_write(CfgConnPorts, links);
    if (spare) cfg_write(CfgSpare, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Coordinate at, next to, or far from this router
  function automatic logic [CoordW-1:0] near_coord(logic [CoordW-1:0] c);
    case ($urandom_range(0, 3))
      0:       return c;
      1:       return c + 1'b1;
      2:       return c - 1'b1;
      default: return CoordW'($urandom);
    endcase
  endfunction

  // Mostly packets with a routable head, then ticks; some tick runs and noise
  task automatic run_traffic(int n_items, int tick_max);
    int               sent;
    int               len;
    int               nt;
    logic [PortW-1:0] p;
    in_item_t         junk;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          p   = ($urandom_range(0, 9) == 0) ? PortW'($urandom_range(5, 7))
                                            : PortW'($urandom_range(0, 4));
          len = $urandom_range(1, 8);
          arrive(p, {near_coord(rtr_x), near_coord(rtr_y), 16'($urandom)});
          for (int i = 1; i < len; i++) arrive(p, FlitBits'($urandom));
          nt = $urandom_range(0, len * tick_max / 2 + tick_max);
          tick(nt);
          sent += len + nt;
        end
        6, 7: begin
          nt = $urandom_range(1, 3 * tick_max);
          tick(nt);
          sent += nt;
        end
        default: begin
          junk = in_item_t'(ItemBits'({$urandom, $urandom}));
          send_item(junk);
          sent++;
        end
      endcase
    end
  endtask

  // Each port gets one packet heading a different way, plus drops above port four
  task automatic test_routes();
    gaps_on = 1'b0;
    set_router(8'h80, 8'h80, 8'h1F, 1'b0);
    arrive(PortEast,  32'h8080_0000);
    arrive(PortEast,  32'hFFFF_FFFF);
    arrive(PortWest,  32'h0000_0000);
    arrive(PortNorth, 32'h80FF_1234);
    arrive(PortSouth, 32'h8000_ABCD);
    arrive(PortLocal, 32'hFFFF_FFFF);
    arrive(3'd5,      32'h1234_5678);
    arrive(3'd7,      32'hFFFF_FFFF);
    // local first, then east..south, then one idle poll
    tick(12);
  endtask

  // Link dropped while its packet is in flight, leftovers wait for relink
  task automatic test_link_loss();
    set_router(8'h00, 8'hFF, 8'h1F, 1'b0);
    arrive(PortWest, 32'h00FF_0001);
    arrive(PortWest, 32'h0000_0002);
    arrive(PortWest, 32'h0000_0003);
    tick(3);
    arrive(PortWest, 32'hFF00_0004);
    arrive(PortWest, 32'h0001_0005);
    set_router(8'h00, 8'hFF, 8'h1D, 1'b0);
    tick(2);
    arrive(PortWest, 32'hDEAD_BEEF);
    tick(5);
    set_router(8'h00, 8'hFF, 8'h1F, 1'b0);
    tick(7);
  endtask

  task automatic test_random_phases();
    gaps_on = 1'b0;
    set_router(8'h00, 8'h00, 8'h1F, 1'b0);
    run_traffic(150, 4);
    gaps_on = 1'b1;
    set_router(8'hFF, 8'hFF, 8'h1F, 1'b0);
    run_traffic(150, 4);
    set_router(8'hFF, 8'h00, 8'hE0 | CfgDataW'($urandom_range(0, 31)), 1'b1);
    run_traffic(120, 4);
    set_router(8'h00, 8'hFF, 8'h11, 1'b0);
    run_traffic(120, 4);
    gaps_on = 1'b0;
    set_router(CoordW'($urandom), CoordW'($urandom), 8'h00, 1'b0);
    run_traffic(40, 4);
    // arrival-heavy traffic fills queues to overflow
    gaps_on = 1'b1;
    set_router(CoordW'($urandom), CoordW'($urandom), 8'h1F, 1'b1);
    run_traffic(90, 1);
    drain_results();
    run_traffic(90, 1);
    set_router(CoordW'($urandom), CoordW'($urandom), 8'hFF, 1'b0);
    run_traffic(100, 4);
  endtask

  initial begin
    shadow_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_routes();
    test_link_loss();
    test_random_phases();
    drain_results();
    if (mismatch_cnt == 0) begin
      $display("xy_wormhole_router_5port_top regression: pass");
    end else begin
      $display("xy_wormhole_router_5port_top regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/xyr_pkg.sv
rtl/xyr_fifo.sv
rtl/xy_wormhole_router_5port_top.sv
rtl/xyr_checker.sv
tb/tb_xy_wormhole_router_5port_top.sv
